FILE: rtl/core/nv21_to_bgr_resize_rotate_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the NV21 to BGR core
// ----------------------------------------------------------------------------
`ifndef NV21_TO_BGR_RESIZE_ROTATE_CORE_DEFINES_SVH
`define NV21_TO_BGR_RESIZE_ROTATE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define NBRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define NBRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nbrr_pkg.sv
// ----------------------------------------------------------------------------
// nbrr_pkg
// Shared types, codes and fixed widths of the NV21 to BGR resize/rotate core.
// ----------------------------------------------------------------------------
package nbrr_pkg;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int DIM_W      = 11;
    localparam int STEP_W     = 26;
    localparam int ROT_W      = 3;
    localparam int BADDR_W    = 21;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int K_W        = 11;
    localparam int PROD_W     = K_W + STEP_W;
    localparam int POS_W      = PROD_W - 16;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [ROT_W-1:0]  t_rot;
    typedef logic [PIX_W-1:0]  t_pix;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Rotation codes
    localparam t_rot ROT_0   = 3'd0;
    localparam t_rot ROT_90  = 3'd1;
    localparam t_rot ROT_180 = 3'd2;
    localparam t_rot ROT_270 = 3'd3;

    // Chroma byte order
    localparam logic CHROMA_NV21 = 1'b0;
    localparam logic CHROMA_NV12 = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_ORDER = 3'd7;

    // Register reset values
    localparam t_dim  RST_SRC_WIDTH  = 11'd640;
    localparam t_dim  RST_SRC_HEIGHT = 11'd480;
    localparam t_dim  RST_DST_WIDTH  = 11'd320;
    localparam t_dim  RST_DST_HEIGHT = 11'd240;
    localparam t_step RST_STEP       = 26'd131072;

endpackage

FILE: rtl/core/nv21_to_bgr_resize_rotate_core.sv
// ----------------------------------------------------------------------------
// nv21_to_bgr_resize_rotate_core
// Frame store for a semi-planar YUV 4:2:0 frame with nearest-neighbour
// resize, rotation and BT.601 YUV to BGR conversion of requested pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): each transfer is either a frame
//   byte write (i_cmd = write) or a pixel request (i_cmd = pixel) that names
//   an output row and column. Writes give no result; each request gives one.
//   Output channel (o_out_valid / i_out_ready): blue, green, red and the
//   bad_rotation flag, in request order.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while no request is in flight.
//   A request moves through the stage registers and then the result register.
//   Throughput: one transfer per cycle while results are taken; the Y copy
//   and the two chroma banks each read one byte per cycle while not stalled.
//   Writes take effect in pipeline order, so a request sees exactly the
//   writes transferred before it.
//   Reset clears the pipeline valids and loads the register defaults; the
//   frame store is not cleared and must be written before it is read.
//   When the receiver stalls the whole pipeline holds and o_in_ready drops.
// ----------------------------------------------------------------------------
module nv21_to_bgr_resize_rotate_core #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nbrr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nbrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [nbrr_pkg::BADDR_W-1:0]    i_byte_addr,
    input  logic [nbrr_pkg::PIX_W-1:0]      i_byte_value,
    input  logic [nbrr_pkg::COORD_W-1:0]    i_out_row,
    input  logic [nbrr_pkg::COORD_W-1:0]    i_out_col,
    // Results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nbrr_pkg::PIX_W-1:0]      o_blue,
    output logic [nbrr_pkg::PIX_W-1:0]      o_green,
    output logic [nbrr_pkg::PIX_W-1:0]      o_red,
    output logic                            o_bad_rotation
);

    // Store geometry
    localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int BAW         = AW - 1;
    localparam int HALF_BYTES  = (STORE_BYTES + 1) / 2;
    localparam int RW          = $clog2(MAX_HEIGHT);
    localparam int CLW         = $clog2(MAX_WIDTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);

    // Color arithmetic
    localparam int CW = COEF_FRAC_BITS + 3;
    localparam int PW = CW + 10;
    localparam int SW = PW + 2;
    localparam logic signed [CW-1:0] C_Y  = CW'(((1164 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [CW-1:0] C_B  = CW'(((2018 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [CW-1:0] C_GV = CW'(((813 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [CW-1:0] C_GU = CW'(((391 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [CW-1:0] C_R  = CW'(((1596 << COEF_FRAC_BITS) + 500) / 1000);

    // Truncate a Q sum to a byte, clamping to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [SW-1:0] s);
        logic [SW-1:0] sh;
        logic [7:0]    res;
        sh = s >> COEF_FRAC_BITS;
        if (s < 0) begin
            res = 8'd0;
        end else if (|sh[SW-1:8]) begin
            res = 8'd255;
        end else begin
            res = sh[7:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    nbrr_pkg::t_dim  r_src_width, r_src_height, r_dst_width, r_dst_height;
    nbrr_pkg::t_step r_col_step, r_row_step;
    nbrr_pkg::t_rot  r_rotation;
    logic            r_chroma_order;

    assign o_cfg_ready = 1'b1;

    // Take register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= nbrr_pkg::RST_SRC_WIDTH;
            r_src_height   <= nbrr_pkg::RST_SRC_HEIGHT;
            r_dst_width    <= nbrr_pkg::RST_DST_WIDTH;
            r_dst_height   <= nbrr_pkg::RST_DST_HEIGHT;
            r_col_step     <= nbrr_pkg::RST_STEP;
            r_row_step     <= nbrr_pkg::RST_STEP;
            r_rotation     <= nbrr_pkg::ROT_0;
            r_chroma_order <= nbrr_pkg::CHROMA_NV21;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nbrr_pkg::CFG_SRC_WIDTH:    r_src_width    <= i_cfg_data[nbrr_pkg::DIM_W-1:0];
                nbrr_pkg::CFG_SRC_HEIGHT:   r_src_height   <= i_cfg_data[nbrr_pkg::DIM_W-1:0];
                nbrr_pkg::CFG_DST_WIDTH:    r_dst_width    <= i_cfg_data[nbrr_pkg::DIM_W-1:0];
                nbrr_pkg::CFG_DST_HEIGHT:   r_dst_height   <= i_cfg_data[nbrr_pkg::DIM_W-1:0];
                nbrr_pkg::CFG_COL_STEP:     r_col_step     <= i_cfg_data[nbrr_pkg::STEP_W-1:0];
                nbrr_pkg::CFG_ROW_STEP:     r_row_step     <= i_cfg_data[nbrr_pkg::STEP_W-1:0];
                nbrr_pkg::CFG_ROTATION:     r_rotation     <= i_cfg_data[nbrr_pkg::ROT_W-1:0];
                nbrr_pkg::CFG_CHROMA_ORDER: r_chroma_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Limit the frame size to 1..MAX
    logic [WW-1:0] w_lim;
    logic [HW-1:0] h_lim;
    logic [WW+HW-1:0] area;

    always_comb begin
        if (r_src_width == '0) begin
            w_lim = WW'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = WW'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_lim = HW'(1);
        end else if (32'(r_src_height) > 32'(MAX_HEIGHT)) begin
            h_lim = HW'(MAX_HEIGHT);
        end else begin
            h_lim = HW'(r_src_height);
        end
    end

    assign area = w_lim * h_lim;

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together
    // ------------------------------------------------------------------
    logic en;
    logic r_out_valid;
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid, r7_valid;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Advance valid bits; drop writes at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= r6_valid;
            r_out_valid <= r7_valid && (r7_cmd == nbrr_pkg::CMD_PIXEL);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: rotate the output coordinate into row/column indexes
    // ------------------------------------------------------------------
    logic signed [12:0] dw_s, dh_s, row_s, col_s, n_kr_s, n_kc_s;
    logic [nbrr_pkg::K_W-1:0] n_kr, n_kc;
    logic n_bad, n_wr_ok;

    assign dw_s  = $signed({2'b0, r_dst_width});
    assign dh_s  = $signed({2'b0, r_dst_height});
    assign row_s = $signed({3'b0, i_out_row});
    assign col_s = $signed({3'b0, i_out_col});

    always_comb begin
        case (r_rotation)
            nbrr_pkg::ROT_90: begin
                n_kr_s = col_s;
                n_kc_s = dw_s - 13'sd1 - row_s;
            end
            nbrr_pkg::ROT_180: begin
                n_kr_s = dh_s - 13'sd1 - row_s;
                n_kc_s = dw_s - 13'sd1 - col_s;
            end
            nbrr_pkg::ROT_270: begin
                n_kr_s = dh_s - 13'sd1 - col_s;
                n_kc_s = row_s;
            end
            default: begin
                n_kr_s = row_s;
                n_kc_s = col_s;
            end
        endcase
        // A negative index maps to source zero
        n_kr    = n_kr_s[12] ? '0 : n_kr_s[nbrr_pkg::K_W-1:0];
        n_kc    = n_kc_s[12] ? '0 : n_kc_s[nbrr_pkg::K_W-1:0];
        n_bad   = r_rotation > nbrr_pkg::ROT_270;
        n_wr_ok = {11'b0, i_byte_addr} < 32'(STORE_BYTES);
    end

    logic [nbrr_pkg::K_W-1:0]     r1_kr, r1_kc;
    logic                         r1_cmd, r1_bad, r1_wr_ok;
    logic [nbrr_pkg::BADDR_W-1:0] r1_addr;
    logic [nbrr_pkg::PIX_W-1:0]   r1_value;

    // ------------------------------------------------------------------
    // Stage 2: scale by the Q10.16 steps
    // ------------------------------------------------------------------
    logic [nbrr_pkg::PROD_W-1:0]  prow, pcol;
    logic [nbrr_pkg::POS_W-1:0]   r2_prow, r2_pcol;
    logic                         r2_cmd, r2_bad, r2_wr_ok;
    logic [nbrr_pkg::BADDR_W-1:0] r2_addr;
    logic [nbrr_pkg::PIX_W-1:0]   r2_value;

    assign prow = r1_kr * r_row_step;
    assign pcol = r1_kc * r_col_step;

    // ------------------------------------------------------------------
    // Stage 3: saturate to the image
    // ------------------------------------------------------------------
    logic [HW-1:0]  h_m1;
    logic [WW-1:0]  w_m1;
    logic [RW-1:0]  n_srow;
    logic [CLW-1:0] n_scol;
    logic [RW-1:0]  r3_srow;
    logic [CLW-1:0] r3_scol;
    logic           r3_cmd, r3_bad, r3_wr_ok;
    logic [nbrr_pkg::BADDR_W-1:0] r3_addr;
    logic [nbrr_pkg::PIX_W-1:0]   r3_value;

    assign h_m1   = h_lim - 1'b1;
    assign w_m1   = w_lim - 1'b1;
    assign n_srow = (r2_prow > nbrr_pkg::POS_W'(h_m1)) ? RW'(h_m1) : RW'(r2_prow);
    assign n_scol = (r2_pcol > nbrr_pkg::POS_W'(w_m1)) ? CLW'(w_m1) : CLW'(r2_pcol);

    // ------------------------------------------------------------------
    // Stage 4: row offsets of luma and chroma
    // ------------------------------------------------------------------
    logic [RW+WW-1:0]   my;
    logic [RW+WW-2:0]   mc;
    logic [AW-1:0]      r4_my, r4_mc;
    logic [CLW-1:0]     r4_scol;
    logic               r4_cmd, r4_bad, r4_wr_ok;
    logic [nbrr_pkg::BADDR_W-1:0] r4_addr;
    logic [nbrr_pkg::PIX_W-1:0]   r4_value;

    assign my = r3_srow * w_lim;
    assign mc = r3_srow[RW-1:1] * w_lim;

    // ------------------------------------------------------------------
    // Stage 5: byte addresses
    // ------------------------------------------------------------------
    logic [AW-1:0] r_area;
    logic [AW-1:0] scol_even;
    logic [AW-1:0] r5_yaddr, r5_caddr;
    logic          r5_cmd, r5_bad, r5_wr_ok;
    logic [nbrr_pkg::BADDR_W-1:0] r5_addr;
    logic [nbrr_pkg::PIX_W-1:0]   r5_value;

    assign scol_even = AW'({r4_scol[CLW-1:1], 1'b0});

    // ------------------------------------------------------------------
    // Stage 6: frame store access (writes and reads in item order)
    // ------------------------------------------------------------------
    logic [7:0] mem_y    [STORE_BYTES];
    logic [7:0] mem_even [HALF_BYTES];
    logic [7:0] mem_odd  [HALF_BYTES];

    logic [AW:0]     c_inc;
    logic [BAW-1:0]  rd_even_idx, rd_odd_idx;
    logic [AW-1:0]   wr_idx;
    logic            wr_en;

    assign c_inc       = {1'b0, r5_caddr} + 1'b1;
    assign rd_even_idx = c_inc[BAW:1];
    assign rd_odd_idx  = r5_caddr[AW-1:1];
    assign wr_idx      = AW'(r5_addr);
    assign wr_en       = en && r5_valid && (r5_cmd == nbrr_pkg::CMD_WRITE) && r5_wr_ok;

    logic [7:0] r6_y, r6_even, r6_odd;
    logic       r6_codd, r6_cmd, r6_bad;

    // Luma copy of the store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_y[wr_idx] <= r5_value;
        end
        if (en) begin
            r6_y <= mem_y[r5_yaddr];
        end
    end

    // Even byte bank
    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_idx[0]) begin
            mem_even[wr_idx[AW-1:1]] <= r5_value;
        end
        if (en) begin
            r6_even <= mem_even[rd_even_idx];
        end
    end

    // Odd byte bank
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_idx[0]) begin
            mem_odd[wr_idx[AW-1:1]] <= r5_value;
        end
        if (en) begin
            r6_odd <= mem_odd[rd_odd_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: chroma pair order and coefficient products
    // ------------------------------------------------------------------
    logic [7:0]         first_b, second_b, u_b, v_b;
    logic signed [9:0]  yd, ud, vd;
    logic signed [PW-1:0] r7_ly, r7_tb, r7_tgv, r7_tgu, r7_tr;
    logic               r7_cmd, r7_bad;

    always_comb begin
        first_b  = r6_codd ? r6_odd  : r6_even;
        second_b = r6_codd ? r6_even : r6_odd;
        if (r_chroma_order == nbrr_pkg::CHROMA_NV21) begin
            v_b = first_b;
            u_b = second_b;
        end else begin
            u_b = first_b;
            v_b = second_b;
        end
        yd = $signed({2'b0, r6_y}) - 10'sd16;
        ud = $signed({2'b0, u_b})  - 10'sd128;
        vd = $signed({2'b0, v_b})  - 10'sd128;
    end

    // ------------------------------------------------------------------
    // Output stage: sums, clamp, result register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_b, sum_g, sum_r;
    logic [7:0] r_blue, r_green, r_red;
    logic       r_bad;

    assign sum_b = r7_ly + r7_tb;
    assign sum_g = r7_ly - r7_tgv - r7_tgu;
    assign sum_r = r7_ly + r7_tr;

    // Advance payload through the stages
    always_ff @(posedge i_clk) begin
        r_area <= AW'(area);
        if (en) begin
            // stage 1
            r1_kr    <= n_kr;
            r1_kc    <= n_kc;
            r1_cmd   <= i_cmd;
            r1_bad   <= n_bad;
            r1_wr_ok <= n_wr_ok;
            r1_addr  <= i_byte_addr;
            r1_value <= i_byte_value;
            // stage 2
            r2_prow  <= prow[nbrr_pkg::PROD_W-1:16];
            r2_pcol  <= pcol[nbrr_pkg::PROD_W-1:16];
            r2_cmd   <= r1_cmd;
            r2_bad   <= r1_bad;
            r2_wr_ok <= r1_wr_ok;
            r2_addr  <= r1_addr;
            r2_value <= r1_value;
            // stage 3
            r3_srow  <= n_srow;
            r3_scol  <= n_scol;
            r3_cmd   <= r2_cmd;
            r3_bad   <= r2_bad;
            r3_wr_ok <= r2_wr_ok;
            r3_addr  <= r2_addr;
            r3_value <= r2_value;
            // stage 4
            r4_my    <= AW'(my);
            r4_mc    <= AW'(mc);
            r4_scol  <= r3_scol;
            r4_cmd   <= r3_cmd;
            r4_bad   <= r3_bad;
            r4_wr_ok <= r3_wr_ok;
            r4_addr  <= r3_addr;
            r4_value <= r3_value;
            // stage 5
            r5_yaddr <= r4_my + AW'(r4_scol);
            r5_caddr <= r_area + r4_mc + scol_even;
            r5_cmd   <= r4_cmd;
            r5_bad   <= r4_bad;
            r5_wr_ok <= r4_wr_ok;
            r5_addr  <= r4_addr;
            r5_value <= r4_value;
            // stage 6 (read data registered in the store blocks)
            r6_codd  <= r5_caddr[0];
            r6_cmd   <= r5_cmd;
            r6_bad   <= r5_bad;
            // stage 7
            r7_ly    <= yd * C_Y;
            r7_tb    <= ud * C_B;
            r7_tgv   <= vd * C_GV;
            r7_tgu   <= ud * C_GU;
            r7_tr    <= vd * C_R;
            r7_cmd   <= r6_cmd;
            r7_bad   <= r6_bad;
            // result
            r_bad    <= r7_bad;
            r_blue   <= r7_bad ? 8'd0 : clamp_byte(sum_b);
            r_green  <= r7_bad ? 8'd0 : clamp_byte(sum_g);
            r_red    <= r7_bad ? 8'd0 : clamp_byte(sum_r);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_blue         = r_blue;
    assign o_green        = r_green;
    assign o_red          = r_red;
    assign o_bad_rotation = r_bad;

endmodule

FILE: rtl/core/nbrr_checker.sv
// ----------------------------------------------------------------------------
// nbrr_checker
// Port-level checks of the NV21 to BGR core, attached by bind.
// ----------------------------------------------------------------------------
`include "nv21_to_bgr_resize_rotate_core_defines.svh"

module nbrr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [nbrr_pkg::PIX_W-1:0] o_blue,
    input logic [nbrr_pkg::PIX_W-1:0] o_green,
    input logic [nbrr_pkg::PIX_W-1:0] o_red,
    input logic                       o_bad_rotation
);

    // Hold a stalled result
    `NBRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_blue) && $stable(o_green) && $stable(o_red) && $stable(o_bad_rotation), "stalled result changed")

    // Unsupported rotation gives black
    `NBRR_ASSERT_NOW(a_bad_black, i_clk, i_rst_n, o_out_valid && o_bad_rotation, (o_blue == 8'd0) && (o_green == 8'd0) && (o_red == 8'd0), "bad rotation result not black")

    // Input side stalls only behind a blocked result
    `NBRR_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without output backpressure")

endmodule

bind nv21_to_bgr_resize_rotate_core nbrr_checker u_nbrr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_blue         (o_blue),
    .o_green        (o_green),
    .o_red          (o_red),
    .o_bad_rotation (o_bad_rotation)
);
